// File: design/yhp_pkg.sv
// Shared types, constants and the microcode program of the yaw hold PID/PWM block.
// Used by yhp_seq, yhp_dpath and yaw_hold_pid_pwm_top; depends on nothing else.
package yhp_pkg;

    localparam int YAW_W      = 16;
    localparam int ERR_W      = 17;
    localparam int WRAP_W     = 18;
    localparam int SUM_W      = 25;
    localparam int MUL_W      = 26;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 43;
    localparam int LIM_W      = 28;
    localparam int SCL_SHIFT  = 18;
    localparam int MAG_W      = LIM_W + 8 - SCL_SHIFT;
    localparam int QUO_SHIFT  = 28;
    localparam int QUO_W      = 8;
    localparam int PWM_W      = 9;
    localparam int GAIN_W     = 12;
    localparam int BAND_W     = 14;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic signed [WRAP_W-1:0] FULL_TURN  = 18'sd23040;
    localparam logic signed [WRAP_W-1:0] HALF_TURN  = 18'sd11520;
    localparam logic signed [SUM_W:0]    SUM_MAX    = 26'sd16777215;
    localparam logic signed [SUM_W:0]    SUM_MIN    = -26'sd16777216;
    localparam logic [LIM_W-1:0]         DRIVE_LIMIT = 28'd163840000;

    // multiplier constants: 50 and 2500 from the PID scaling, reciprocal of 625 at 2^28
    localparam logic signed [MUL_W-1:0] K_PROP  = 26'sd50;
    localparam logic signed [MUL_W-1:0] K_DERIV = 26'sd2500;
    localparam logic signed [MUL_W-1:0] K_RECIP = 26'sd429497;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 2'd3;

    localparam logic [GAIN_W-1:0] RST_GAIN_PROP  = 12'd614;
    localparam logic [GAIN_W-1:0] RST_GAIN_INTEG = 12'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_DERIV = 12'd128;
    localparam logic [BAND_W-1:0] RST_DEAD_BAND  = 14'd64;

    typedef enum logic [2:0] {A_PROP, A_INTEG, A_DERIV, A_PROD, A_MAG} a_sel_t;
    typedef enum logic [2:0] {B_KPROP, B_KDERIV, B_ERR, B_DY, B_SUM, B_RECIP} b_sel_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
    typedef enum logic [2:0] {OP_NOP, OP_ERR, OP_CLAMP, OP_QUOT, OP_LATCH} dp_op_t;
    typedef enum logic {JMP_NONE, JMP_UNSET} jmp_t;

    typedef struct packed {
        a_sel_t             a_sel;
        b_sel_t             b_sel;
        logic               mul_en;
        acc_op_t            acc_op;
        dp_op_t             dp_op;
        jmp_t               jmp;
        logic [STEP_W-1:0]  jmp_to;
        logic               fin;
    } ctrl_t;

    typedef struct packed {
        logic taken;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integ;
        logic [GAIN_W-1:0] gain_deriv;
        logic [BAND_W-1:0] dead_band;
    } cfg_t;

    localparam ctrl_t CTRL_NOP = '{a_sel: A_PROP, b_sel: B_KPROP, mul_en: 1'b0,
                                   acc_op: ACC_HOLD, dp_op: OP_NOP, jmp: JMP_NONE,
                                   jmp_to: '0, fin: 1'b0};

    localparam logic [STEP_W-1:0] ST_CHECK = 4'd0;
    localparam logic [STEP_W-1:0] ST_ERR   = 4'd1;
    localparam logic [STEP_W-1:0] ST_MP0   = 4'd2;
    localparam logic [STEP_W-1:0] ST_MP1   = 4'd3;
    localparam logic [STEP_W-1:0] ST_MD0   = 4'd4;
    localparam logic [STEP_W-1:0] ST_MD1   = 4'd5;
    localparam logic [STEP_W-1:0] ST_MI    = 4'd6;
    localparam logic [STEP_W-1:0] ST_ACC   = 4'd7;
    localparam logic [STEP_W-1:0] ST_CLAMP = 4'd8;
    localparam logic [STEP_W-1:0] ST_MQ    = 4'd9;
    localparam logic [STEP_W-1:0] ST_QUOT  = 4'd10;
    localparam logic [STEP_W-1:0] ST_LATCH = 4'd11;

    // Program:
    //   check  -> latch path on first sample
    //   err    e, error sum, dy
    //   P*50, *e -> acc ; D*2500, *dy -> acc+ ; I*sum -> acc+
    //   clamp/scale by 255/2^18, times 1/625 reciprocal, quotient out
    function automatic ctrl_t ucode_word(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = CTRL_NOP;
        unique case (step)
            ST_CHECK:
            begin
                w.jmp    = JMP_UNSET;
                w.jmp_to = ST_LATCH;
            end
            ST_ERR:   w.dp_op = OP_ERR;
            ST_MP0:
            begin
                w.mul_en = 1'b1;
                w.a_sel  = A_PROP;
                w.b_sel  = B_KPROP;
            end
            ST_MP1:
            begin
                w.mul_en = 1'b1;
                w.a_sel  = A_PROD;
                w.b_sel  = B_ERR;
            end
            ST_MD0:
            begin
                w.acc_op = ACC_LOAD;
                w.mul_en = 1'b1;
                w.a_sel  = A_DERIV;
                w.b_sel  = B_KDERIV;
            end
            ST_MD1:
            begin
                w.mul_en = 1'b1;
                w.a_sel  = A_PROD;
                w.b_sel  = B_DY;
            end
            ST_MI:
            begin
                w.acc_op = ACC_ADD;
                w.mul_en = 1'b1;
                w.a_sel  = A_INTEG;
                w.b_sel  = B_SUM;
            end
            ST_ACC:   w.acc_op = ACC_ADD;
            ST_CLAMP: w.dp_op  = OP_CLAMP;
            ST_MQ:
            begin
                w.mul_en = 1'b1;
                w.a_sel  = A_MAG;
                w.b_sel  = B_RECIP;
            end
            ST_QUOT:
            begin
                w.dp_op = OP_QUOT;
                w.fin   = 1'b1;
            end
            ST_LATCH:
            begin
                w.dp_op = OP_LATCH;
                w.fin   = 1'b1;
            end
            default:  w = CTRL_NOP;
        endcase
        return w;
    endfunction

endpackage

// File: design/yaw_hold_pid_pwm_top.sv
// Top level of the yaw hold PID/PWM controller: configuration registers,
// sequencer and datapath. Depends on yhp_pkg, yhp_seq, yhp_dpath.
//
//  channel  | handshake              | word
//  ---------+------------------------+-------------------------------------
//  sample   | sample_valid/stall     | yaw_sample[15:0]
//  result   | result_valid/stall     | pwm_drive[8:0], heading_error[15:0]
//  cfg      | cfg_valid/cfg_ready    | cfg_index[1:0], cfg_data[13:0]
//
// The first sample after reset runs the check and latch steps (latch path) and gives no word.
// Each later sample runs 11 microcode steps through one shared 26x26 multiplier
// (six products); a new sample is taken on the last step.
// The final step waits while the result register holds an untaken word.
// Reset clears setpoint, last yaw, error sum and loads the default gains.
module yaw_hold_pid_pwm_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic signed [yhp_pkg::YAW_W-1:0]       yaw_sample,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [yhp_pkg::PWM_W-1:0]       pwm_drive,
    output logic signed [yhp_pkg::YAW_W-1:0]       heading_error,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [yhp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [yhp_pkg::CFG_DATA_W-1:0]         cfg_data
);

    yhp_pkg::cfg_t   cfg_reg;
    yhp_pkg::cfg_t   cfg_next;
    yhp_pkg::ctrl_t  ctrl;
    yhp_pkg::stat_t  stat;
    logic            sample_load;
    logic [yhp_pkg::YAW_W-1:0] herr_abs;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                yhp_pkg::REG_GAIN_PROP:  cfg_next.gain_prop  = cfg_data[yhp_pkg::GAIN_W-1:0];
                yhp_pkg::REG_GAIN_INTEG: cfg_next.gain_integ = cfg_data[yhp_pkg::GAIN_W-1:0];
                yhp_pkg::REG_GAIN_DERIV: cfg_next.gain_deriv = cfg_data[yhp_pkg::GAIN_W-1:0];
                yhp_pkg::REG_DEAD_BAND:  cfg_next.dead_band  = cfg_data[yhp_pkg::BAND_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop  <= yhp_pkg::RST_GAIN_PROP;
            cfg_reg.gain_integ <= yhp_pkg::RST_GAIN_INTEG;
            cfg_reg.gain_deriv <= yhp_pkg::RST_GAIN_DERIV;
            cfg_reg.dead_band  <= yhp_pkg::RST_DEAD_BAND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    yhp_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_load  (sample_load),
        .stat         (stat),
        .ctrl         (ctrl)
    );

    yhp_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .cfg           (cfg_reg),
        .sample_load   (sample_load),
        .yaw_sample    (yaw_sample),
        .result_stall  (result_stall),
        .result_valid  (result_valid),
        .pwm_drive     (pwm_drive),
        .heading_error (heading_error),
        .stat          (stat)
    );

    assign herr_abs = heading_error[yhp_pkg::YAW_W-1] ? yhp_pkg::YAW_W'(-heading_error)
                                                      : yhp_pkg::YAW_W'(heading_error);

    // an accepted sample keeps the sequencer busy the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> sample_stall)
        else $error("sample taken while previous one still in work");

    // a new word only appears right after the quotient step
    a_result_from_program: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(ctrl.dp_op == yhp_pkg::OP_QUOT))
        else $error("result word without a sample in work");

    // nonzero drive only outside the dead band
    a_dead_band: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && pwm_drive != '0) |-> !(herr_abs < yhp_pkg::YAW_W'(cfg_reg.dead_band)))
        else $error("drive inside dead band");

    a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pwm_drive != -9'sd256))
        else $error("pwm drive out of range");

endmodule

// File: design/yhp_seq.sv
// Microcode sequencer: step counter, program ROM lookup, jumps and input handshake.
// Depends on yhp_pkg.
module yhp_seq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    output logic                 sample_load,
    input  yhp_pkg::stat_t       stat,
    output yhp_pkg::ctrl_t       ctrl
);

    logic                        busy_reg;
    logic                        busy_next;
    logic [yhp_pkg::STEP_W-1:0]  step_reg;
    logic [yhp_pkg::STEP_W-1:0]  step_next;
    yhp_pkg::ctrl_t              rom_word;
    logic                        hold;
    logic                        finishing;
    logic                        jump_taken;

    assign rom_word = yhp_pkg::ucode_word(step_reg);

    // quotient step waits for the output register to free up
    assign hold       = busy_reg && (rom_word.dp_op == yhp_pkg::OP_QUOT) && !stat.out_free;
    assign finishing  = busy_reg && !hold && rom_word.fin;
    assign jump_taken = (rom_word.jmp == yhp_pkg::JMP_UNSET) && !stat.taken;

    assign sample_stall = busy_reg && !finishing;
    assign sample_load  = sample_valid && !sample_stall;
    assign ctrl         = (busy_reg && !hold) ? rom_word : yhp_pkg::CTRL_NOP;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (sample_load)
        begin
            busy_next = 1'b1;
            step_next = yhp_pkg::ST_CHECK;
        end
        else if (busy_reg && !hold)
        begin
            if (rom_word.fin)
            begin
                busy_next = 1'b0;
            end
            else if (jump_taken)
            begin
                step_next = rom_word.jmp_to;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

// File: design/yhp_dpath.sv
// Datapath: heading state, wrapped error, saturating sum, shared multiplier,
// accumulator, clamp/scale and the output register. Depends on yhp_pkg.
module yhp_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  yhp_pkg::ctrl_t                    ctrl,
    input  yhp_pkg::cfg_t                     cfg,
    input  logic                              sample_load,
    input  logic signed [yhp_pkg::YAW_W-1:0]  yaw_sample,
    input  logic                              result_stall,
    output logic                              result_valid,
    output logic signed [yhp_pkg::PWM_W-1:0]  pwm_drive,
    output logic signed [yhp_pkg::YAW_W-1:0]  heading_error,
    output yhp_pkg::stat_t                    stat
);

    localparam int W = yhp_pkg::WRAP_W;

    logic signed [yhp_pkg::YAW_W-1:0]   yaw_reg;
    logic signed [yhp_pkg::YAW_W-1:0]   target_reg;
    logic signed [yhp_pkg::YAW_W-1:0]   last_yaw_reg;
    logic                               taken_reg;
    logic signed [yhp_pkg::SUM_W-1:0]   sum_reg;
    logic signed [yhp_pkg::ERR_W-1:0]   err_reg;
    logic signed [yhp_pkg::ERR_W-1:0]   dy_reg;
    logic signed [yhp_pkg::PROD_W-1:0]  prod_reg;
    logic signed [yhp_pkg::ACC_W-1:0]   acc_reg;
    logic signed [yhp_pkg::ACC_W-1:0]   acc_next;
    logic [yhp_pkg::MAG_W-1:0]          mag_reg;
    logic                               neg_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [yhp_pkg::PWM_W-1:0]   pwm_reg;
    logic signed [yhp_pkg::YAW_W-1:0]   herr_reg;

    logic signed [W-1:0]                yaw_w;
    logic signed [W-1:0]                err_raw;
    logic signed [W-1:0]                err_alt;
    logic [W-1:0]                       raw_abs;
    logic [W-1:0]                       alt_abs;
    logic signed [yhp_pkg::ERR_W-1:0]   err_new;
    logic signed [yhp_pkg::SUM_W:0]     sum_wide;
    logic signed [yhp_pkg::SUM_W-1:0]   sum_new;
    logic signed [yhp_pkg::ERR_W-1:0]   dy_new;
    logic signed [W-1:0]                tgt_wide;

    logic signed [yhp_pkg::MUL_W-1:0]   mul_a;
    logic signed [yhp_pkg::MUL_W-1:0]   mul_b;
    logic signed [yhp_pkg::PROD_W-1:0]  mul_res;

    logic [yhp_pkg::ACC_W-1:0]          acc_abs;
    logic [yhp_pkg::LIM_W-1:0]          lim;
    logic [yhp_pkg::LIM_W+7:0]          scaled;

    logic [yhp_pkg::QUO_W-1:0]          quo;
    logic signed [yhp_pkg::PWM_W-1:0]   pwm_val;
    logic [yhp_pkg::ERR_W-1:0]          err_abs;
    logic                               in_band;

    // error wrap and state updates
    always_comb
    begin
        yaw_w   = W'(yaw_reg);
        err_raw = W'(target_reg) - yaw_w;
        err_alt = err_raw[W-1] ? (err_raw + yhp_pkg::FULL_TURN)
                               : (err_raw - yhp_pkg::FULL_TURN);
        raw_abs = err_raw[W-1] ? W'(-err_raw) : W'(err_raw);
        alt_abs = err_alt[W-1] ? W'(-err_alt) : W'(err_alt);
        err_new = (alt_abs < raw_abs) ? err_alt[yhp_pkg::ERR_W-1:0]
                                      : err_raw[yhp_pkg::ERR_W-1:0];
        sum_wide = (yhp_pkg::SUM_W+1)'(sum_reg) + (yhp_pkg::SUM_W+1)'(err_new);
        if (sum_wide > yhp_pkg::SUM_MAX)
        begin
            sum_new = yhp_pkg::SUM_MAX[yhp_pkg::SUM_W-1:0];
        end
        else if (sum_wide < yhp_pkg::SUM_MIN)
        begin
            sum_new = yhp_pkg::SUM_MIN[yhp_pkg::SUM_W-1:0];
        end
        else
        begin
            sum_new = sum_wide[yhp_pkg::SUM_W-1:0];
        end
        dy_new = yhp_pkg::ERR_W'(yaw_reg) - yhp_pkg::ERR_W'(last_yaw_reg);
        // setpoint fold, applied once at latch
        if (yaw_w >= yhp_pkg::HALF_TURN)
        begin
            tgt_wide = yaw_w - yhp_pkg::FULL_TURN;
        end
        else if (yaw_w < -yhp_pkg::HALF_TURN)
        begin
            tgt_wide = yaw_w + yhp_pkg::FULL_TURN;
        end
        else
        begin
            tgt_wide = yaw_w;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (ctrl.a_sel)
            yhp_pkg::A_PROP:  mul_a = yhp_pkg::MUL_W'(cfg.gain_prop);
            yhp_pkg::A_INTEG: mul_a = yhp_pkg::MUL_W'(cfg.gain_integ);
            yhp_pkg::A_DERIV: mul_a = yhp_pkg::MUL_W'(cfg.gain_deriv);
            yhp_pkg::A_PROD:  mul_a = prod_reg[yhp_pkg::MUL_W-1:0];
            yhp_pkg::A_MAG:   mul_a = yhp_pkg::MUL_W'(mag_reg);
            default:          mul_a = '0;
        endcase
        unique case (ctrl.b_sel)
            yhp_pkg::B_KPROP:  mul_b = yhp_pkg::K_PROP;
            yhp_pkg::B_KDERIV: mul_b = yhp_pkg::K_DERIV;
            yhp_pkg::B_ERR:    mul_b = yhp_pkg::MUL_W'(err_reg);
            yhp_pkg::B_DY:     mul_b = yhp_pkg::MUL_W'(dy_reg);
            yhp_pkg::B_SUM:    mul_b = yhp_pkg::MUL_W'(sum_reg);
            yhp_pkg::B_RECIP:  mul_b = yhp_pkg::K_RECIP;
            default:           mul_b = '0;
        endcase
    end

    assign mul_res = yhp_pkg::PROD_W'(mul_a) * yhp_pkg::PROD_W'(mul_b);

    always_comb
    begin
        unique case (ctrl.acc_op)
            yhp_pkg::ACC_LOAD: acc_next = $signed(prod_reg[yhp_pkg::ACC_W-1:0]);
            yhp_pkg::ACC_ADD:  acc_next = acc_reg + $signed(prod_reg[yhp_pkg::ACC_W-1:0]);
            default:           acc_next = acc_reg;
        endcase
    end

    // clamp to the drive limit, then times 255 and down by 2^18 (limit = 625 * 2^18)
    always_comb
    begin
        acc_abs = acc_reg[yhp_pkg::ACC_W-1] ? yhp_pkg::ACC_W'(-acc_reg) : yhp_pkg::ACC_W'(acc_reg);
        lim     = (acc_abs > yhp_pkg::ACC_W'(yhp_pkg::DRIVE_LIMIT)) ? yhp_pkg::DRIVE_LIMIT
                                                                     : acc_abs[yhp_pkg::LIM_W-1:0];
        scaled  = {lim, 8'd0} - {8'd0, lim};
    end

    always_comb
    begin
        quo     = prod_reg[yhp_pkg::QUO_SHIFT+yhp_pkg::QUO_W-1:yhp_pkg::QUO_SHIFT];
        pwm_val = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        err_abs = err_reg[yhp_pkg::ERR_W-1] ? yhp_pkg::ERR_W'(-err_reg)
                                            : yhp_pkg::ERR_W'(err_reg);
        in_band = err_abs < yhp_pkg::ERR_W'(cfg.dead_band);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        if (ctrl.dp_op == yhp_pkg::OP_QUOT)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg     <= 1'b0;
            target_reg    <= '0;
            last_yaw_reg  <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctrl.dp_op == yhp_pkg::OP_ERR)
            begin
                sum_reg      <= sum_new;
                last_yaw_reg <= yaw_reg;
            end
            if (ctrl.dp_op == yhp_pkg::OP_LATCH)
            begin
                taken_reg    <= 1'b1;
                target_reg   <= tgt_wide[yhp_pkg::YAW_W-1:0];
                last_yaw_reg <= yaw_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_load)
        begin
            yaw_reg <= yaw_sample;
        end
        if (ctrl.dp_op == yhp_pkg::OP_ERR)
        begin
            err_reg <= err_new;
            dy_reg  <= dy_new;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_res;
        end
        acc_reg <= acc_next;
        if (ctrl.dp_op == yhp_pkg::OP_CLAMP)
        begin
            neg_reg <= acc_reg[yhp_pkg::ACC_W-1];
            mag_reg <= scaled[yhp_pkg::LIM_W+7:yhp_pkg::SCL_SHIFT];
        end
        if (ctrl.dp_op == yhp_pkg::OP_QUOT)
        begin
            pwm_reg  <= in_band ? '0 : pwm_val;
            herr_reg <= err_reg[yhp_pkg::YAW_W-1:0];
        end
    end

    assign result_valid  = out_valid_reg;
    assign pwm_drive     = pwm_reg;
    assign heading_error = herr_reg;
    assign stat.taken    = taken_reg;
    assign stat.out_free = !out_valid_reg || !result_stall;

endmodule
